[src/bsd_pkg.sv]
// Package: shared types and constants of the BMP LSB stego decoder.
`timescale 1ns / 1ps
`default_nettype none

package bsd_pkg;

   // Configuration register reset values
   localparam logic [7:0]  HEADER_LENGTH_RESET = 8'd54;
   localparam logic [15:0] MAGIC_WORD_RESET    = 16'd8995;

   // Configuration port geometry
   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   // Register indexes (paddr[2])
   localparam logic REG_HEADER_LENGTH = 1'b0;
   localparam logic REG_MAGIC_WORD    = 1'b1;

   // Result kinds
   localparam logic [1:0] KIND_EXT  = 2'd0;
   localparam logic [1:0] KIND_PAY  = 2'd1;
   localparam logic [1:0] KIND_BAD  = 2'd2;
   localparam logic [1:0] KIND_DONE = 2'd3;

   // Input item
   typedef struct packed {
      logic [7:0] pixel_byte;
      logic       new_image;
   } req_item_type;

   // Result item
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] value;
      logic       last;
   } rsp_item_type;

   // Configuration seen by the parser
   typedef struct packed {
      logic [7:0]  header_length;
      logic [15:0] magic_word;
   } cfg_type;

endpackage

`default_nettype wire

[src/bsd_csr.sv]
// Module: configuration registers behind the APB-style port.
`timescale 1ns / 1ps
`default_nettype none

module bsd_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [bsd_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  wire logic [bsd_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic      [bsd_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                      csr_pready,
   output bsd_pkg::cfg_type                          cfg
);

   logic [7:0]  header_length_ff;
   logic [7:0]  header_length_in;
   logic [15:0] magic_word_ff;
   logic [15:0] magic_word_in;
   logic        wr_en;
   logic        reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   // word index; the low two address bits are byte lanes
   assign reg_sel    = csr_paddr[2];

   // register write decode
   always_comb begin
      header_length_in = header_length_ff;
      magic_word_in    = magic_word_ff;
      if (wr_en) begin
         case (reg_sel)
            bsd_pkg::REG_HEADER_LENGTH: header_length_in = csr_pwdata[7:0];
            bsd_pkg::REG_MAGIC_WORD:    magic_word_in    = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_length_ff <= bsd_pkg::HEADER_LENGTH_RESET;
         magic_word_ff    <= bsd_pkg::MAGIC_WORD_RESET;
      end else begin
         header_length_ff <= header_length_in;
         magic_word_ff    <= magic_word_in;
      end
   end

   // read mux
   always_comb begin
      case (reg_sel)
         bsd_pkg::REG_HEADER_LENGTH: csr_prdata = {24'd0, header_length_ff};
         bsd_pkg::REG_MAGIC_WORD:    csr_prdata = {16'd0, magic_word_ff};
         default:                    csr_prdata = '0;
      endcase
   end

   assign cfg.header_length = header_length_ff;
   assign cfg.magic_word    = magic_word_ff;

endmodule

`default_nettype wire

[src/bsd_parse.sv]
// Module: file parser state machine, one item per step.
`timescale 1ns / 1ps
`default_nettype none

module bsd_parse (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire bsd_pkg::cfg_type      cfg,
   input  wire logic                  step,
   input  wire bsd_pkg::req_item_type item,
   output logic                       emit,
   output bsd_pkg::rsp_item_type      result
);

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_MAGIC,
      PH_EXT_LEN,
      PH_EXT,
      PH_PAY_LEN,
      PH_PAY,
      PH_IDLE
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  header_count_ff, header_count_in;
   logic [4:0]  bit_count_ff, bit_count_in;
   logic [31:0] bit_shift_ff, bit_shift_in;
   logic [30:0] remaining_ff, remaining_in;

   phase_type   cur_phase;
   logic [7:0]  cur_hc;
   logic [4:0]  cur_bc;
   logic [31:0] cur_bs;
   logic [30:0] cur_rem;
   logic        skip;
   logic [31:0] gathered;
   logic [30:0] length;
   logic [30:0] rem_dec;
   logic [4:0]  bc_inc;

   // next-state logic for one item
   always_comb begin
      cur_phase = phase_ff;
      cur_hc    = header_count_ff;
      cur_bc    = bit_count_ff;
      cur_bs    = bit_shift_ff;
      cur_rem   = remaining_ff;
      skip      = 1'b0;
      emit      = 1'b0;
      result    = '0;

      // new file restarts the parse on this very item
      if (item.new_image) begin
         cur_phase = PH_HEADER;
         cur_hc    = '0;
         cur_bc    = '0;
         cur_bs    = '0;
         cur_rem   = '0;
      end

      header_count_in = cur_hc;
      if (cur_phase == PH_HEADER) begin
         if (cur_hc < cfg.header_length) begin
            header_count_in = cur_hc + 8'd1;
            skip            = 1'b1;
         end else begin
            cur_phase = PH_MAGIC;
            cur_bc    = '0;
            cur_bs    = '0;
         end
      end

      // bit gathering, LSB first
      gathered         = cur_bs;
      gathered[cur_bc] = item.pixel_byte[0];
      bc_inc           = cur_bc + 5'd1;
      length           = gathered[31] ? '0 : gathered[30:0];
      rem_dec          = cur_rem - 31'd1;

      phase_in     = cur_phase;
      bit_count_in = cur_bc;
      bit_shift_in = cur_bs;
      remaining_in = cur_rem;

      if (!skip) begin
         case (cur_phase)
            PH_MAGIC: begin
               if (cur_bc >= 5'd15) begin
                  bit_count_in = '0;
                  bit_shift_in = '0;
                  if (gathered[15:0] != cfg.magic_word) begin
                     phase_in    = PH_IDLE;
                     emit        = 1'b1;
                     result.kind = bsd_pkg::KIND_BAD;
                     result.last = 1'b1;
                  end else begin
                     phase_in = PH_EXT_LEN;
                  end
               end else begin
                  bit_count_in = bc_inc;
                  bit_shift_in = gathered;
               end
            end
            PH_EXT_LEN: begin
               if (cur_bc >= 5'd31) begin
                  bit_count_in = '0;
                  bit_shift_in = '0;
                  remaining_in = length;
                  phase_in     = (length != '0) ? PH_EXT : PH_PAY_LEN;
               end else begin
                  bit_count_in = bc_inc;
                  bit_shift_in = gathered;
               end
            end
            PH_EXT: begin
               if (cur_bc >= 5'd7) begin
                  bit_count_in = '0;
                  bit_shift_in = '0;
                  remaining_in = rem_dec;
                  if (rem_dec == '0) begin
                     phase_in = PH_PAY_LEN;
                  end
                  emit         = 1'b1;
                  result.kind  = bsd_pkg::KIND_EXT;
                  result.value = gathered[7:0];
               end else begin
                  bit_count_in = bc_inc;
                  bit_shift_in = gathered;
               end
            end
            PH_PAY_LEN: begin
               if (cur_bc >= 5'd31) begin
                  bit_count_in = '0;
                  bit_shift_in = '0;
                  remaining_in = length;
                  if (length == '0) begin
                     phase_in    = PH_IDLE;
                     emit        = 1'b1;
                     result.kind = bsd_pkg::KIND_DONE;
                     result.last = 1'b1;
                  end else begin
                     phase_in = PH_PAY;
                  end
               end else begin
                  bit_count_in = bc_inc;
                  bit_shift_in = gathered;
               end
            end
            PH_PAY: begin
               if (cur_bc >= 5'd7) begin
                  bit_count_in = '0;
                  bit_shift_in = '0;
                  remaining_in = rem_dec;
                  emit         = 1'b1;
                  result.kind  = bsd_pkg::KIND_PAY;
                  result.value = gathered[7:0];
                  if (rem_dec == '0) begin
                     phase_in    = PH_IDLE;
                     result.last = 1'b1;
                  end
               end else begin
                  bit_count_in = bc_inc;
                  bit_shift_in = gathered;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEADER;
         header_count_ff <= '0;
         bit_count_ff    <= '0;
         bit_shift_ff    <= '0;
         remaining_ff    <= '0;
      end else if (step) begin
         phase_ff        <= phase_in;
         header_count_ff <= header_count_in;
         bit_count_ff    <= bit_count_in;
         bit_shift_ff    <= bit_shift_in;
         remaining_ff    <= remaining_in;
      end
   end

   // a final result always leaves the parser halted
   a_last_halts: assert property (@(posedge clock) disable iff (reset)
      step && emit && result.last |=> phase_ff == PH_IDLE)
      else $error("final result did not halt the parser");

   // a halted parser stays silent until a new file starts
   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == PH_IDLE && !item.new_image |-> !emit)
      else $error("result emitted while halted");

   // character sections gather at most eight bits
   a_char_bits: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_EXT || phase_ff == PH_PAY) |-> bit_count_ff < 5'd8)
      else $error("character bit count out of range");

   // a character section is never entered with nothing left
   a_rem_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_EXT || phase_ff == PH_PAY) |-> remaining_ff != '0)
      else $error("character section with zero count");

endmodule

`default_nettype wire

[src/bsd_out_reg.sv]
// Module: result register towards the rsp channel.
`timescale 1ns / 1ps
`default_nettype none

module bsd_out_reg (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire bsd_pkg::rsp_item_type load_data,
   output logic                       blocked,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output bsd_pkg::rsp_item_type      rsp_data
);

   logic                  valid_ff, valid_in;
   bsd_pkg::rsp_item_type data_ff, data_in;

   // a held item that is stalled blocks the stage in front
   assign blocked = valid_ff & rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

[src/bmp_lsb_stego_decoder_unit.sv]
// An accepted item is held in the input register; the parser steps on it from there
// and loads any result into the result register. Throughput: one item per cycle when
// no held result is stalled; the parser is a single registered step. A stalled held
// result holds the input register, which then stalls the input channel.
// Synchronous active-high reset clears the parse to header skip and sets
// header_length to 54 and magic_word to 8995; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module bmp_lsb_stego_decoder_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // input channel
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire bsd_pkg::req_item_type                req_data,
   // result channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output bsd_pkg::rsp_item_type                     rsp_data,
   // configuration port
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [bsd_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  wire logic [bsd_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic      [bsd_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                      csr_pready
);

   bsd_pkg::cfg_type      cfg;
   logic                  in_valid_ff, in_valid_in;
   bsd_pkg::req_item_type in_data_ff, in_data_in;
   logic                  req_accept;
   logic                  proceed;
   logic                  out_blocked;
   logic                  emit;
   bsd_pkg::rsp_item_type result;

   bsd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // input register: the held item moves on unless the result side is blocked
   assign proceed    = in_valid_ff & ~out_blocked;
   assign req_stall  = in_valid_ff & ~proceed;
   assign req_accept = req_valid & ~req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end else if (proceed) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_data_ff <= in_data_in;
   end

   bsd_parse u_parse (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .step   (proceed),
      .item   (in_data_ff),
      .emit   (emit),
      .result (result)
   );

   bsd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (proceed & emit),
      .load_data (result),
      .blocked   (out_blocked),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
